### hw/rtl/cha_pkg.sv
`timescale 1ns / 1ps
package cha_pkg;

  localparam int PoolW   = 15;
  localparam int CmdW    = 3;
  localparam int SizeW   = 17;
  localparam int HandleW = 8;
  localparam int OffW    = 14;
  localparam int DataW   = 32;
  localparam int StatusW = 3;
  localparam int BaseW   = 14;
  localparam int WordsW  = 15;

  localparam logic [CmdW-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CmdW-1:0] CMD_FREE    = 3'd1;
  localparam logic [CmdW-1:0] CMD_READ    = 3'd2;
  localparam logic [CmdW-1:0] CMD_WRITE   = 3'd3;
  localparam logic [CmdW-1:0] CMD_COMPACT = 3'd4;

  localparam logic [StatusW-1:0] STS_OK         = 3'd0;
  localparam logic [StatusW-1:0] STS_NO_MEM     = 3'd1;
  localparam logic [StatusW-1:0] STS_NO_HANDLE  = 3'd2;
  localparam logic [StatusW-1:0] STS_NOT_LIVE   = 3'd3;
  localparam logic [StatusW-1:0] STS_BAD_OFFSET = 3'd4;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [SizeW-1:0]   size_bytes;
    logic [HandleW-1:0] handle;
    logic [OffW-1:0]    word_offset;
    logic [DataW-1:0]   write_data;
  } cmd_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HandleW-1:0] given_handle;
    logic [BaseW-1:0]   base_word;
    logic [DataW-1:0]   read_data;
    logic               compacted;
  } res_item_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LATCH,
    OP_EVAL,
    OP_RDATA,
    OP_GRANT,
    OP_CP_START,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_SCAN_TAIL,
    OP_PICK,
    OP_PLACE,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_compact;
    logic alloc_ok;
    logic need_comp;
    logic read_go;
    logic scan_last;
    logic best_found;
    logic need_copy;
    logic copy_last;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/cha_stream_if.sv
`timescale 1ns / 1ps
interface cha_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/cha_ctrl.sv
`timescale 1ns / 1ps
module cha_ctrl
  import cha_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_EVAL      = 4'd2;
  localparam logic [3:0] S_RDATA     = 4'd3;
  localparam logic [3:0] S_GRANT     = 4'd4;
  localparam logic [3:0] S_CP_START  = 4'd5;
  localparam logic [3:0] S_SCAN_INIT = 4'd6;
  localparam logic [3:0] S_SCAN      = 4'd7;
  localparam logic [3:0] S_SCAN_TAIL = 4'd8;
  localparam logic [3:0] S_PICK      = 4'd9;
  localparam logic [3:0] S_PLACE     = 4'd10;
  localparam logic [3:0] S_COPY_RD   = 4'd11;
  localparam logic [3:0] S_COPY_WR   = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    op_o       = OP_IDLE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        op_o = OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_LATCH;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        op_o = OP_EVAL;
        if (stat_i.read_go) state_d = S_RDATA;
        else if (stat_i.is_compact || (stat_i.alloc_ok && stat_i.need_comp))
          state_d = S_CP_START;
        else if (stat_i.alloc_ok) state_d = S_GRANT;
        else state_d = S_DONE;
      end
      S_RDATA: begin
        op_o    = OP_RDATA;
        state_d = S_DONE;
      end
      S_GRANT: begin
        op_o    = OP_GRANT;
        state_d = S_DONE;
      end
      S_CP_START: begin
        op_o    = OP_CP_START;
        state_d = S_SCAN_INIT;
      end
      S_SCAN_INIT: begin
        op_o    = OP_SCAN_INIT;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        op_o = OP_SCAN;
        if (stat_i.scan_last) state_d = S_SCAN_TAIL;
      end
      S_SCAN_TAIL: begin
        op_o    = OP_SCAN_TAIL;
        state_d = S_PICK;
      end
      S_PICK: begin
        op_o = OP_PICK;
        if (stat_i.best_found) state_d = S_PLACE;
        else if (stat_i.is_alloc) state_d = S_GRANT;
        else state_d = S_DONE;
      end
      S_PLACE: begin
        op_o    = OP_PLACE;
        state_d = stat_i.need_copy ? S_COPY_RD : S_SCAN_INIT;
      end
      S_COPY_RD: begin
        op_o    = OP_COPY_RD;
        state_d = S_COPY_WR;
      end
      S_COPY_WR: begin
        op_o    = OP_COPY_WR;
        state_d = stat_i.copy_last ? S_SCAN_INIT : S_COPY_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          op_o    = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

endmodule

### hw/rtl/cha_datapath.sv
`timescale 1ns / 1ps
module cha_datapath
  import cha_pkg::*;
#(
  parameter int HANDLES   = 256,
  parameter int MAX_WORDS = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PoolW-1:0] cfg_wdata_i,
  input  dp_op_e           op_i,
  input  cmd_item_t        cmd_i,
  output res_item_t        res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output dp_stat_t         stat_o
);

  localparam int HW        = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int SCW       = $clog2(HANDLES + 1);
  localparam int AW        = $clog2(MAX_WORDS);
  localparam int CW        = $clog2(MAX_WORDS + 1);
  localparam int KW        = CW + HW;
  localparam int PoolReset = (MAX_WORDS < 16384) ? MAX_WORDS : 16384;

  // storage
  logic [CW-1:0]    base_mem  [HANDLES];
  logic [CW-1:0]    words_mem [HANDLES];
  logic [HW-1:0]    spare_mem [HANDLES];
  logic [DataW-1:0] data_mem  [MAX_WORDS];

  logic [HANDLES-1:0] live_q, spare_vld_q;
  logic [CW-1:0]      pool_q, bump_q, tail_q, total_q;
  logic [SCW-1:0]     spare_cnt_q;
  cmd_item_t          cmd_q;
  logic [WordsW:0]    words_q;
  logic [CW-1:0]      base_rd_q, words_rd_q;
  logic [HW-1:0]      spare_rd_q, spare_rd_idx_q;
  logic               spare_rd_vld_q;
  logic [DataW-1:0]   data_rd_q;
  res_item_t          res_q, out_q;
  logic               out_valid_q;
  logic [AW-1:0]      clr_q;
  logic [HW-1:0]      scan_q, cand_q;
  logic               cand_vld_q;
  logic [KW-1:0]      best_key_q, last_key_q;
  logic               best_found_q, have_last_q;
  logic [CW-1:0]      left_q, src_q, dst_q, rem_q;

  logic [HW-1:0]   hidx, spare_top, grant_h, base_raddr;
  logic            live, nomem, no_handle, need_comp, off_bad, in_rng, push;
  logic [31:0]     acc_addr;
  logic [KW-1:0]   cand_key;
  logic            cand_take, copy_ok;
  logic [CW-1:0]   cfg_pool;
  logic [SizeW:0]  wsum;
  logic            data_re, data_we;
  logic [AW-1:0]   data_raddr, data_waddr;
  logic [DataW-1:0] data_wdata;

  assign hidx      = HW'(cmd_q.handle);
  assign live      = (32'(cmd_q.handle) < HANDLES) && live_q[hidx];
  assign nomem     = 32'(words_q) > 32'(total_q);
  assign no_handle = (spare_cnt_q == '0);
  assign need_comp = 32'(words_q) > 32'(tail_q);
  assign off_bad   = 32'(cmd_q.word_offset) >= 32'(words_rd_q);
  assign acc_addr  = 32'(base_rd_q) + 32'(cmd_q.word_offset);
  assign in_rng    = acc_addr < MAX_WORDS;
  assign spare_top = HW'(spare_cnt_q - SCW'(1));
  assign grant_h   = spare_rd_vld_q ? spare_rd_q : spare_rd_idx_q;
  assign push      = (op_i == OP_EVAL) && (cmd_q.command == CMD_FREE) && live &&
                     (spare_cnt_q < SCW'(HANDLES));
  assign cand_key  = {base_rd_q, cand_q};
  assign cand_take = cand_vld_q && live_q[cand_q] &&
                     (!have_last_q || (cand_key > last_key_q)) &&
                     (!best_found_q || (cand_key < best_key_q));
  assign copy_ok   = (32'(src_q) < MAX_WORDS) && (32'(dst_q) < MAX_WORDS);
  assign cfg_pool  = (32'(cfg_wdata_i) > MAX_WORDS) ? CW'(MAX_WORDS) : CW'(cfg_wdata_i);
  assign wsum      = (SizeW+1)'(cmd_i.size_bytes) + (SizeW+1)'(3);

  always_comb begin
    case (op_i)
      OP_LATCH: base_raddr = HW'(cmd_i.handle);
      OP_SCAN:  base_raddr = scan_q;
      default:  base_raddr = best_key_q[HW-1:0];
    endcase
  end

  always_comb begin
    data_re    = 1'b0;
    data_we    = 1'b0;
    data_raddr = AW'(acc_addr);
    data_waddr = AW'(acc_addr);
    data_wdata = cmd_q.write_data;
    case (op_i)
      OP_CLEAR: begin
        data_we    = 1'b1;
        data_waddr = clr_q;
        data_wdata = '0;
      end
      OP_EVAL: begin
        if (live && !off_bad && in_rng) begin
          data_re = (cmd_q.command == CMD_READ);
          data_we = (cmd_q.command == CMD_WRITE);
        end
      end
      OP_COPY_RD: begin
        data_re    = copy_ok;
        data_raddr = AW'(src_q);
      end
      OP_COPY_WR: begin
        data_we    = copy_ok;
        data_waddr = AW'(dst_q);
        data_wdata = data_rd_q;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    base_rd_q  <= base_mem[base_raddr];
    words_rd_q <= words_mem[base_raddr];
    if (op_i == OP_GRANT) begin
      base_mem[grant_h]  <= bump_q;
      words_mem[grant_h] <= CW'(words_q);
    end else if (op_i == OP_PLACE && base_rd_q != left_q) begin
      base_mem[best_key_q[HW-1:0]] <= left_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_LATCH) spare_rd_q <= spare_mem[spare_top];
    if (push) spare_mem[HW'(spare_cnt_q)] <= hidx;
  end

  always_ff @(posedge clk_i) begin
    if (data_re) data_rd_q <= data_mem[data_raddr];
    if (data_we) data_mem[data_waddr] <= data_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q         <= '0;
      spare_vld_q    <= '0;
      pool_q         <= CW'(PoolReset);
      bump_q         <= '0;
      tail_q         <= CW'(PoolReset);
      total_q        <= CW'(PoolReset);
      spare_cnt_q    <= SCW'(HANDLES);
      cmd_q          <= '0;
      words_q        <= '0;
      spare_rd_idx_q <= '0;
      spare_rd_vld_q <= 1'b0;
      res_q          <= '0;
      clr_q          <= '0;
      scan_q         <= '0;
      cand_q         <= '0;
      cand_vld_q     <= 1'b0;
      best_key_q     <= '0;
      best_found_q   <= 1'b0;
      last_key_q     <= '0;
      have_last_q    <= 1'b0;
      left_q         <= '0;
      src_q          <= '0;
      dst_q          <= '0;
      rem_q          <= '0;
    end else if (cfg_we_i) begin
      pool_q      <= cfg_pool;
      live_q      <= '0;
      spare_vld_q <= '0;
      spare_cnt_q <= SCW'(HANDLES);
      bump_q      <= '0;
      tail_q      <= cfg_pool;
      total_q     <= cfg_pool;
    end else begin
      case (op_i)
        OP_CLEAR: clr_q <= clr_q + AW'(1);
        OP_LATCH: begin
          cmd_q          <= cmd_i;
          words_q        <= (WordsW+1)'(wsum >> 2);
          res_q          <= '0;
          spare_rd_idx_q <= spare_top;
          spare_rd_vld_q <= spare_vld_q[spare_top];
        end
        OP_EVAL: begin
          case (cmd_q.command) inside
            CMD_ALLOC: begin
              if (nomem) res_q.status <= STS_NO_MEM;
              else if (no_handle) res_q.status <= STS_NO_HANDLE;
            end
            CMD_FREE: begin
              if (!live) begin
                res_q.status <= STS_NOT_LIVE;
              end else begin
                live_q[hidx] <= 1'b0;
                total_q      <= total_q + words_rd_q;
                if (push) begin
                  spare_vld_q[HW'(spare_cnt_q)] <= 1'b1;
                  spare_cnt_q                   <= spare_cnt_q + SCW'(1);
                end
              end
            end
            CMD_READ, CMD_WRITE: begin
              if (!live) res_q.status <= STS_NOT_LIVE;
              else if (off_bad) res_q.status <= STS_BAD_OFFSET;
            end
            default: ;
          endcase
        end
        OP_RDATA: res_q.read_data <= data_rd_q;
        OP_GRANT: begin
          live_q[grant_h]    <= 1'b1;
          spare_cnt_q        <= spare_cnt_q - SCW'(1);
          bump_q             <= bump_q + CW'(words_q);
          tail_q             <= tail_q - CW'(words_q);
          total_q            <= total_q - CW'(words_q);
          res_q.given_handle <= HandleW'(grant_h);
          res_q.base_word    <= BaseW'(bump_q);
        end
        OP_CP_START: begin
          left_q          <= '0;
          have_last_q     <= 1'b0;
          res_q.compacted <= 1'b1;
        end
        OP_SCAN_INIT: begin
          scan_q       <= '0;
          best_found_q <= 1'b0;
          cand_vld_q   <= 1'b0;
        end
        OP_SCAN: begin
          scan_q     <= scan_q + HW'(1);
          cand_q     <= scan_q;
          cand_vld_q <= 1'b1;
          if (cand_take) begin
            best_key_q   <= cand_key;
            best_found_q <= 1'b1;
          end
        end
        OP_SCAN_TAIL: begin
          cand_vld_q <= 1'b0;
          if (cand_take) begin
            best_key_q   <= cand_key;
            best_found_q <= 1'b1;
          end
        end
        OP_PICK: begin
          if (best_found_q) begin
            last_key_q  <= best_key_q;
            have_last_q <= 1'b1;
          end else begin
            bump_q <= left_q;
            tail_q <= total_q;
          end
        end
        OP_PLACE: begin
          src_q  <= base_rd_q;
          dst_q  <= left_q;
          rem_q  <= words_rd_q;
          left_q <= left_q + words_rd_q;
        end
        OP_COPY_WR: begin
          src_q <= src_q + CW'(1);
          dst_q <= dst_q + CW'(1);
          rem_q <= rem_q - CW'(1);
        end
        default: ;
      endcase
    end
  end

  // output register, one result held while the next item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (op_i == OP_EMIT) begin
      out_valid_q <= 1'b1;
      out_q       <= res_q;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  always_comb begin
    stat_o            = '0;
    stat_o.clr_last   = (clr_q == AW'(MAX_WORDS - 1));
    stat_o.is_alloc   = (cmd_q.command == CMD_ALLOC);
    stat_o.is_compact = (cmd_q.command == CMD_COMPACT);
    stat_o.alloc_ok   = (cmd_q.command == CMD_ALLOC) && !nomem && !no_handle;
    stat_o.need_comp  = need_comp;
    stat_o.read_go    = (cmd_q.command == CMD_READ) && live && !off_bad && in_rng;
    stat_o.scan_last  = (scan_q == HW'(HANDLES - 1));
    stat_o.best_found = best_found_q;
    stat_o.need_copy  = (base_rd_q != left_q) && (words_rd_q != '0);
    stat_o.copy_last  = (rem_q == CW'(1));
    stat_o.out_free   = !out_valid_q || res_ready_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_cnt_q <= SCW'(HANDLES))
    else $error("spare handle count above handle total");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(bump_q) + 32'(tail_q)) == 32'(pool_q))
    else $error("bump pointer and free tail do not span the pool");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q <= total_q) && (total_q <= pool_q))
    else $error("free counters out of order");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_EMIT) |=> out_valid_q)
    else $error("emitted result not presented");

endmodule

### hw/rtl/compacting_handle_allocator.sv
`timescale 1ns / 1ps
// Sequence: the input transfer is followed by evaluation; a successful read then fetches its
// data, and a successful allocate is granted a handle (after compaction if the tail is short).
// The next item can be taken once the result is presented. A result not yet taken holds the
// block in its last step until the output register frees up. Compaction adds a start step,
// then per live block one scan through the base table plus a read and a write step per moved
// word, and one final scan. Reset: the data store is cleared in a pass over all MAX_WORDS
// words, with no input taken; configuration writes reinitialize handles and counters at once.
module compacting_handle_allocator
  import cha_pkg::*;
#(
  parameter int HANDLES   = 256,
  parameter int MAX_WORDS = 16384
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PoolW-1:0] cfg_wdata_i,
  cha_stream_if.sink       cmd_i,
  cha_stream_if.source     res_o
);

  dp_op_e    op;
  dp_stat_t  stat;
  cmd_item_t cmd_payload;
  res_item_t res_payload;
  logic      res_valid;

  assign cmd_payload   = cmd_i.payload;
  assign res_o.payload = res_payload;
  assign res_o.valid   = res_valid;

  cha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .stat_i     (stat),
    .op_o       (op)
  );

  cha_datapath #(
    .HANDLES   (HANDLES),
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op),
    .cmd_i       (cmd_payload),
    .res_o       (res_payload),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .stat_o      (stat)
  );

endmodule
